FILE: rtl/smc_pkg.sv
package smc_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int ANGLE_W    = 32;
  localparam int THR_W      = 25;
  localparam int PERIOD_W   = 31;
  localparam int SINE_W     = 27;
  localparam int TERMS_W    = 5;
  localparam int TERM_W     = 32;
  localparam int PROD_W     = 64;
  localparam int DIV_W      = 13;
  localparam int KIDX_W     = 5;
  localparam int PC_W       = 4;
  localparam int SINE_LIMIT = 33554432;

  localparam logic [THR_W-1:0]    THR_RESET    = 25'd168;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 31'd105360916;
  localparam logic [TERM_W-1:0]   TERM_CAP     = 32'hFFFF_FFFF;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_PERIOD    = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RED,
    OP_RED_FIX,
    OP_INIT,
    OP_ACC,
    OP_MUL_TX,
    OP_SAT,
    OP_MUL_PX,
    OP_MUL_RCP,
    OP_MUL_DIV,
    OP_FIX,
    OP_DONE
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_IN_RANGE,
    C_REM_BUSY,
    C_TERM_LOW,
    C_MORE,
    C_OUT_FULL
  } cond_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic                start;
    logic [ANGLE_W-1:0]  dividend;
    logic [PERIOD_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic                busy;
    logic [PERIOD_W-1:0] rem;
  } rem_stat_t;

  localparam pc_t ST_IDLE   = 4'd0;
  localparam pc_t ST_RED    = 4'd1;
  localparam pc_t ST_REMW   = 4'd2;
  localparam pc_t ST_REMFIX = 4'd3;
  localparam pc_t ST_INIT   = 4'd4;
  localparam pc_t ST_ACC    = 4'd5;
  localparam pc_t ST_M1     = 4'd6;
  localparam pc_t ST_S1     = 4'd7;
  localparam pc_t ST_M2     = 4'd8;
  localparam pc_t ST_S2     = 4'd9;
  localparam pc_t ST_M3     = 4'd10;
  localparam pc_t ST_M4     = 4'd11;
  localparam pc_t ST_FIX    = 4'd12;
  localparam pc_t ST_DONE   = 4'd13;
  localparam pc_t ST_RET    = 4'd14;

  // (2k)(2k+1) for k = index+1
  localparam logic [DIV_W-1:0] DIVISOR [32] = '{
    13'd6,    13'd20,   13'd42,   13'd72,   13'd110,  13'd156,  13'd210,  13'd272,
    13'd342,  13'd420,  13'd506,  13'd600,  13'd702,  13'd812,  13'd930,  13'd1056,
    13'd1190, 13'd1332, 13'd1482, 13'd1640, 13'd1806, 13'd1980, 13'd2162, 13'd2352,
    13'd2550, 13'd2756, 13'd2970, 13'd3192, 13'd3422, 13'd3660, 13'd3906, 13'd4160
  };

  // floor(2^32 / divisor); quotient estimate is low by at most one
  localparam logic [TERM_W-1:0] RECIP [32] = '{
    32'd715827882, 32'd214748364, 32'd102261126, 32'd59652323,
    32'd39045157,  32'd27531841,  32'd20452225,  32'd15790320,
    32'd12558383,  32'd10226112,  32'd8488077,   32'd7158278,
    32'd6118187,   32'd5289368,   32'd4618244,   32'd4067203,
    32'd3609216,   32'd3224449,   32'd2898088,   32'd2618882,
    32'd2378165,   32'd2169175,   32'd1986571,   32'd1826091,
    32'd1684300,   32'd1558406,   32'd1446116,   32'd1345541,
    32'd1255104,   32'd1173488,   32'd1099582,   32'd1032444
  };

  function automatic ucode_t smc_ucode(pc_t pc);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE};
    unique case (pc)
      ST_IDLE:   w = '{op: OP_LOAD,    cond: C_NO_INPUT, target: ST_IDLE};
      ST_RED:    w = '{op: OP_RED,     cond: C_IN_RANGE, target: ST_INIT};
      ST_REMW:   w = '{op: OP_NOP,     cond: C_REM_BUSY, target: ST_REMW};
      ST_REMFIX: w = '{op: OP_RED_FIX, cond: C_NEVER,    target: ST_IDLE};
      ST_INIT:   w = '{op: OP_INIT,    cond: C_NEVER,    target: ST_IDLE};
      ST_ACC:    w = '{op: OP_ACC,     cond: C_TERM_LOW, target: ST_DONE};
      ST_M1:     w = '{op: OP_MUL_TX,  cond: C_NEVER,    target: ST_IDLE};
      ST_S1:     w = '{op: OP_SAT,     cond: C_NEVER,    target: ST_IDLE};
      ST_M2:     w = '{op: OP_MUL_PX,  cond: C_NEVER,    target: ST_IDLE};
      ST_S2:     w = '{op: OP_SAT,     cond: C_NEVER,    target: ST_IDLE};
      ST_M3:     w = '{op: OP_MUL_RCP, cond: C_NEVER,    target: ST_IDLE};
      ST_M4:     w = '{op: OP_MUL_DIV, cond: C_NEVER,    target: ST_IDLE};
      ST_FIX:    w = '{op: OP_FIX,     cond: C_MORE,     target: ST_ACC};
      ST_DONE:   w = '{op: OP_DONE,    cond: C_OUT_FULL, target: ST_DONE};
      ST_RET:    w = '{op: OP_NOP,     cond: C_ALWAYS,   target: ST_IDLE};
      default:   w = '{op: OP_NOP,     cond: C_ALWAYS,   target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/smc_rem.sv
module smc_rem (
  input  logic                clk,
  input  logic                rst_n,
  input  smc_pkg::rem_req_t   req,
  output smc_pkg::rem_stat_t  stat
);

  localparam int AW    = smc_pkg::ANGLE_W;
  localparam int PW    = smc_pkg::PERIOD_W;
  localparam int CNT_W = $clog2(AW);

  logic            busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]   dvd_r, dvd_nxt;
  logic [PW-1:0]   dvs_r, dvs_nxt;
  logic [PW-1:0]   rem_r, rem_nxt;
  logic [PW:0]     trial;
  logic            fits;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_r, dvd_r[AW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[AW-2:0], 1'b0};
      rem_nxt = fits ? PW'(trial - {1'b0, dvs_r}) : PW'(trial);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(AW - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.rem  = rem_r;

endmodule

FILE: rtl/sine_maclaurin_series.sv
// The series stops at the first term below the threshold, or when MAX_TERMS terms have been
//   summed; an angle outside [0, period] first waits on the remainder unit for range reduction.
// Throughput: one item at a time, set by the 32-step remainder unit and the one shared
//   32x32 multiplier; in_tready returns via the return step to idle after the result is loaded,
//   so a new angle is accepted only after the last result is loaded, which waits on out stalls.
// Reset (rst_n low, synchronous): sequencer to idle, output empty, threshold 168, period 105360916.
module sine_maclaurin_series #(
  parameter int MAX_TERMS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // [31:0] angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,    // [26:0] sine_value, [57:27] reduced_angle,
                                    // [62:58] terms_used, [63] zero
  output logic [0:0]  out_tuser,    // [0] not_converged
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW     = smc_pkg::ANGLE_W;
  localparam int PW     = smc_pkg::PERIOD_W;
  localparam int TW     = smc_pkg::TERM_W;
  localparam int FB     = smc_pkg::FRAC_BITS;
  localparam int N_W    = $clog2(MAX_TERMS);
  localparam int USED_W = $clog2(MAX_TERMS + 1);
  localparam int ACC_W  = TW + $clog2(MAX_TERMS) + 1;
  localparam logic signed [ACC_W-1:0] SINE_HI = ACC_W'(smc_pkg::SINE_LIMIT);
  localparam logic signed [ACC_W-1:0] SINE_LO = -SINE_HI;

  // configuration
  logic [smc_pkg::THR_W-1:0] thr_r;
  logic [PW-1:0]             period_r;
  logic                      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= smc_pkg::THR_RESET;
      period_r <= smc_pkg::PERIOD_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == smc_pkg::REG_THRESHOLD) begin
        thr_r <= cfg_pwdata[smc_pkg::THR_W-1:0];
      end else begin
        period_r <= cfg_pwdata[PW-1:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == smc_pkg::REG_PERIOD) ? {1'b0, period_r}
                                                             : 32'(thr_r);

  // sequencer
  smc_pkg::pc_t    pc_r, pc_nxt;
  smc_pkg::ucode_t uc;
  logic            jump;

  // datapath
  logic [AW-1:0]            angle_r, angle_nxt;
  logic [PW-1:0]            x_r, x_nxt;
  logic [TW-1:0]            t_r, t_nxt;
  logic [TW-1:0]            p_r, p_nxt;
  logic [TW-1:0]            q_r, q_nxt;
  logic [smc_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic [USED_W-1:0]        used_r, used_nxt;
  logic [N_W-1:0]           n_r, n_nxt;

  logic [TW-1:0]            mul_a, mul_b;
  logic [smc_pkg::PROD_W-1:0] mul_p;
  logic [TW-1:0]            sat_p;
  logic [smc_pkg::KIDX_W-1:0] kidx;
  logic [smc_pkg::DIV_W-1:0]  div_k;
  logic [TW-1:0]            rcp_k;
  logic [TW-1:0]            fix_rem;

  logic                     neg;
  logic [AW-1:0]            mag;
  logic [PW-1:0]            period_eff;
  logic                     in_range;
  logic                     term_low;
  logic                     last_term;
  smc_pkg::rem_req_t        rem_req;
  smc_pkg::rem_stat_t       rem_stat;

  // output register
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [63:0]               out_data_r, out_data_nxt;
  logic                      out_nc_r, out_nc_nxt;
  logic                      out_full;
  logic                      out_load;
  logic signed [ACC_W-1:0]   sine_sat;

  assign uc = smc_pkg::smc_ucode(pc_r);

  assign neg        = angle_r[AW-1];
  assign mag        = neg ? (~angle_r + 1'b1) : angle_r;
  assign period_eff = (period_r == '0) ? PW'(1) : period_r;
  assign in_range   = !neg && (angle_r <= {1'b0, period_eff});
  assign term_low   = t_r < TW'(thr_r);
  assign last_term  = n_r == N_W'(MAX_TERMS - 1);
  assign out_full   = out_tvalid_r && !out_tready;

  assign kidx  = smc_pkg::KIDX_W'(n_r);
  assign div_k = smc_pkg::DIVISOR[kidx];
  assign rcp_k = smc_pkg::RECIP[kidx];

  assign sat_p   = (prod_r[smc_pkg::PROD_W-1:TW+FB] != '0) ? smc_pkg::TERM_CAP
                                                          : prod_r[TW+FB-1:FB];
  // q*d never exceeds p, so the low word holds it exactly
  assign fix_rem = p_r - prod_r[TW-1:0];

  assign rem_req.start    = (uc.op == smc_pkg::OP_RED) && !in_range;
  assign rem_req.dividend = mag;
  assign rem_req.divisor  = period_eff;

  smc_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .stat  (rem_stat)
  );

  always_comb begin
    unique case (uc.cond)
      smc_pkg::C_NEVER:    jump = 1'b0;
      smc_pkg::C_ALWAYS:   jump = 1'b1;
      smc_pkg::C_NO_INPUT: jump = !in_tvalid;
      smc_pkg::C_IN_RANGE: jump = in_range;
      smc_pkg::C_REM_BUSY: jump = rem_stat.busy;
      smc_pkg::C_TERM_LOW: jump = term_low;
      smc_pkg::C_MORE:     jump = !last_term;
      smc_pkg::C_OUT_FULL: jump = out_full;
      default:             jump = 1'b0;
    endcase
    pc_nxt = jump ? uc.target : pc_r + 1'b1;
  end

  assign in_tready = uc.op == smc_pkg::OP_LOAD;

  always_comb begin
    unique case (uc.op)
      smc_pkg::OP_MUL_TX:  begin mul_a = t_r;               mul_b = {1'b0, x_r}; end
      smc_pkg::OP_MUL_PX:  begin mul_a = p_r;               mul_b = {1'b0, x_r}; end
      smc_pkg::OP_MUL_RCP: begin mul_a = p_r;               mul_b = rcp_k;       end
      smc_pkg::OP_MUL_DIV: begin mul_a = prod_r[63:32];     mul_b = TW'(div_k);  end
      default:             begin mul_a = t_r;               mul_b = {1'b0, x_r}; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    if (acc_r > SINE_HI) begin
      sine_sat = SINE_HI;
    end else if (acc_r < SINE_LO) begin
      sine_sat = SINE_LO;
    end else begin
      sine_sat = acc_r;
    end
  end

  assign out_load = (uc.op == smc_pkg::OP_DONE) && !out_full;

  always_comb begin
    angle_nxt    = angle_r;
    x_nxt        = x_r;
    t_nxt        = t_r;
    p_nxt        = p_r;
    q_nxt        = q_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    used_nxt     = used_r;
    n_nxt        = n_r;
    out_data_nxt = out_data_r;
    out_nc_nxt   = out_nc_r;
    unique case (uc.op)
      smc_pkg::OP_LOAD: begin
        if (in_tvalid) begin
          angle_nxt = in_tdata;
        end
      end
      smc_pkg::OP_RED: begin
        if (in_range) begin
          x_nxt = angle_r[PW-1:0];
        end
      end
      smc_pkg::OP_RED_FIX: begin
        if (!neg) begin
          x_nxt = rem_stat.rem;
        end else if (rem_stat.rem != '0) begin
          x_nxt = period_eff - rem_stat.rem;
        end else begin
          x_nxt = '0;
        end
      end
      smc_pkg::OP_INIT: begin
        t_nxt    = {1'b0, x_r};
        acc_nxt  = '0;
        used_nxt = '0;
        n_nxt    = '0;
      end
      smc_pkg::OP_ACC: begin
        if (!term_low) begin
          // odd-indexed terms are subtracted
          acc_nxt  = n_r[0] ? acc_r - $signed({{(ACC_W-TW){1'b0}}, t_r})
                            : acc_r + $signed({{(ACC_W-TW){1'b0}}, t_r});
          used_nxt = used_r + 1'b1;
        end
      end
      smc_pkg::OP_MUL_TX,
      smc_pkg::OP_MUL_PX,
      smc_pkg::OP_MUL_RCP: begin
        prod_nxt = mul_p;
      end
      smc_pkg::OP_SAT: begin
        p_nxt = sat_p;
      end
      smc_pkg::OP_MUL_DIV: begin
        q_nxt    = prod_r[63:32];
        prod_nxt = mul_p;
      end
      smc_pkg::OP_FIX: begin
        t_nxt = (fix_rem >= TW'(div_k)) ? q_r + 1'b1 : q_r;
        n_nxt = n_r + 1'b1;
      end
      smc_pkg::OP_DONE: begin
        if (out_load) begin
          out_data_nxt = {1'b0, smc_pkg::TERMS_W'(used_r), x_r,
                          sine_sat[smc_pkg::SINE_W-1:0]};
          out_nc_nxt   = (used_r == USED_W'(MAX_TERMS)) && !term_low;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= smc_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      pc_r         <= pc_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    angle_r    <= angle_nxt;
    x_r        <= x_nxt;
    t_r        <= t_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    used_r     <= used_nxt;
    n_r        <= n_nxt;
    out_data_r <= out_data_nxt;
    out_nc_r   <= out_nc_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_nc_r;

  a_rem_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rem_stat.busy |-> pc_r == smc_pkg::ST_REMW)
    else $error("remainder unit busy outside its wait step");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == smc_pkg::ST_ACC |-> used_r < USED_W'(MAX_TERMS))
    else $error("term count reached limit at accumulate step");

  a_quot_low: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == smc_pkg::ST_FIX |-> prod_r[TW-1:0] <= p_r)
    else $error("quotient estimate above true quotient");

  a_quot_err: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == smc_pkg::ST_FIX |-> fix_rem < (TW'(div_k) + TW'(div_k)))
    else $error("quotient estimate low by more than one");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid_r)
    else $error("result not presented after load");

endmodule
